// File: src/mffd_pkg.sv
// ----------------------------------------------------------------------------
// mffd_pkg
// shared types and constants of the motor feedback frame decoder
// ----------------------------------------------------------------------------
package mffd_pkg;

  localparam int CHASSIS_MOTORS = 4;
  localparam int SLOTS          = CHASSIS_MOTORS + 3;
  localparam int SLOT_W         = $clog2(SLOTS);

  localparam logic [SLOT_W-1:0] SLOT_YAW   = SLOT_W'(CHASSIS_MOTORS);
  localparam logic [SLOT_W-1:0] SLOT_PITCH = SLOT_W'(CHASSIS_MOTORS + 1);
  localparam logic [SLOT_W-1:0] SLOT_POKE  = SLOT_W'(CHASSIS_MOTORS + 2);

  localparam logic [2:0] SRC_YAW   = 3'd4;
  localparam logic [2:0] SRC_PITCH = 3'd5;
  localparam logic [2:0] SRC_POKE  = 3'd6;
  localparam logic [2:0] SRC_GYRO  = 3'd7;

  // divide by five: (x * 52429) >> 18 is exact for x below 2^18
  localparam logic [15:0] DIV5_RECIP = 16'd52429;
  localparam int          DIV5_SHIFT = 18;

  localparam logic [16:0] TURN_HALF = 17'sd4096;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [2:0] {
    REG_CHASSIS_BASE  = 3'd0,
    REG_YAW_ID        = 3'd1,
    REG_PITCH_ID      = 3'd2,
    REG_POKE_ID       = 3'd3,
    REG_GYRO_ID       = 3'd4,
    REG_CHASSIS_CALIB = 3'd5,
    REG_POKE_CALIB    = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [10:0] chassis_base_id;
    logic [10:0] yaw_id;
    logic [10:0] pitch_id;
    logic [10:0] poke_id;
    logic [10:0] gyro_id;
    logic [7:0]  chassis_calib_frames;
    logic [7:0]  poke_calib_frames;
  } cfg_t;

  typedef struct packed {
    logic              is_gyro;
    logic [SLOT_W-1:0] slot;
    logic [2:0]        src;
    logic              counted;
    logic [7:0]        limit;
    logic [31:0]       hi;
    logic [13:0]       cur;
    logic [7:0]        hall;
  } item_t;

endpackage

// File: src/mffd_cfg_regs.sv
// ----------------------------------------------------------------------------
// mffd_cfg_regs
// apb register file holding the ids and calibration frame counts
// ----------------------------------------------------------------------------
module mffd_cfg_regs import mffd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  cfg_t cfg_r, cfg_nxt;
  logic [2:0] idx;
  logic       wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[4:2];
  assign wr_en  = psel & penable & pwrite;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_CHASSIS_BASE:  cfg_nxt.chassis_base_id      = pwdata[10:0];
        REG_YAW_ID:        cfg_nxt.yaw_id               = pwdata[10:0];
        REG_PITCH_ID:      cfg_nxt.pitch_id             = pwdata[10:0];
        REG_POKE_ID:       cfg_nxt.poke_id              = pwdata[10:0];
        REG_GYRO_ID:       cfg_nxt.gyro_id              = pwdata[10:0];
        REG_CHASSIS_CALIB: cfg_nxt.chassis_calib_frames = pwdata[7:0];
        REG_POKE_CALIB:    cfg_nxt.poke_calib_frames    = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_CHASSIS_BASE:  prdata = CFG_DATA_W'(cfg_r.chassis_base_id);
      REG_YAW_ID:        prdata = CFG_DATA_W'(cfg_r.yaw_id);
      REG_PITCH_ID:      prdata = CFG_DATA_W'(cfg_r.pitch_id);
      REG_POKE_ID:       prdata = CFG_DATA_W'(cfg_r.poke_id);
      REG_GYRO_ID:       prdata = CFG_DATA_W'(cfg_r.gyro_id);
      REG_CHASSIS_CALIB: prdata = CFG_DATA_W'(cfg_r.chassis_calib_frames);
      REG_POKE_CALIB:    prdata = CFG_DATA_W'(cfg_r.poke_calib_frames);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.chassis_base_id      <= 11'd513;
      cfg_r.yaw_id               <= 11'd517;
      cfg_r.pitch_id             <= 11'd518;
      cfg_r.poke_id              <= 11'd519;
      cfg_r.gyro_id              <= 11'd1025;
      cfg_r.chassis_calib_frames <= 8'd51;
      cfg_r.poke_calib_frames    <= 8'd10;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// File: src/mffd_front.sv
// ----------------------------------------------------------------------------
// mffd_front
// matches the frame id, picks the motor slot and scales the current
// ----------------------------------------------------------------------------
module mffd_front import mffd_pkg::*; (
  input  cfg_t        cfg,
  input  logic [10:0] frame_id,
  input  logic [31:0] bytes_high,
  input  logic [31:0] bytes_low,
  output logic        match,
  output item_t       item
);

  logic [10:0] diff;
  logic        hit_chassis;
  logic [15:0] cur_raw;
  logic        cur_neg;
  logic [15:0] cur_mag;
  logic [31:0] prod;
  logic [12:0] quot;

  assign diff        = frame_id - cfg.chassis_base_id;
  assign hit_chassis = (frame_id >= cfg.chassis_base_id) && (diff < 11'(CHASSIS_MOTORS));

  // current / -5 toward zero: scale the magnitude, then flip the sign
  assign cur_raw = bytes_low[31:16];
  assign cur_neg = cur_raw[15];
  assign cur_mag = cur_neg ? 16'(~cur_raw + 16'd1) : cur_raw;
  assign prod    = cur_mag * DIV5_RECIP;
  assign quot    = prod[DIV5_SHIFT +: 13];

  always_comb begin
    match        = 1'b1;
    item.is_gyro = 1'b0;
    item.slot    = '0;
    item.src     = '0;
    item.counted = 1'b0;
    item.limit   = '0;
    item.hi      = bytes_high;
    item.cur     = cur_neg ? {1'b0, quot} : 14'(-{1'b0, quot});
    item.hall    = bytes_low[15:8];
    if (hit_chassis) begin
      item.slot    = diff[SLOT_W-1:0];
      item.src     = diff[2:0];
      item.counted = 1'b1;
      item.limit   = cfg.chassis_calib_frames;
    end else if (frame_id == cfg.yaw_id) begin
      item.slot = SLOT_YAW;
      item.src  = SRC_YAW;
    end else if (frame_id == cfg.pitch_id) begin
      item.slot = SLOT_PITCH;
      item.src  = SRC_PITCH;
    end else if (frame_id == cfg.poke_id) begin
      item.slot    = SLOT_POKE;
      item.src     = SRC_POKE;
      item.counted = 1'b1;
      item.limit   = cfg.poke_calib_frames;
    end else if (frame_id == cfg.gyro_id) begin
      item.is_gyro = 1'b1;
      item.src     = SRC_GYRO;
    end else begin
      match = 1'b0;
    end
  end

endmodule

// File: src/mffd_queue.sv
// ----------------------------------------------------------------------------
// mffd_queue
// small fifo of classified items between front and back
// ----------------------------------------------------------------------------
module mffd_queue import mffd_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  not_empty,
  output item_t head
);

  item_t             mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;

  assign full      = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// File: src/mffd_back.sv
// ----------------------------------------------------------------------------
// mffd_back
// per-motor angle tracking and the registered result
// ----------------------------------------------------------------------------
module mffd_back import mffd_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         item_valid,
  input  item_t        item,
  output logic         item_pop,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [2:0]   source,
  output logic         calibrating,
  output logic [15:0]  raw_angle,
  output logic [15:0]  rotor_speed,
  output logic [13:0]  drive_current,
  output logic [7:0]   hall_value,
  output logic [31:0]  round_count,
  output logic [45:0]  accum_angle,
  output logic [31:0]  gyro_angle
);

  logic [15:0] angle_r  [SLOTS];
  logic [15:0] offset_r [SLOTS];
  logic [31:0] rounds_r [SLOTS];
  logic [7:0]  fcount_r [SLOTS];

  logic        out_valid_r;
  logic [2:0]  source_r;
  logic        calib_r;
  logic [15:0] raw_angle_r;
  logic [15:0] speed_r;
  logic [13:0] cur_r;
  logic [7:0]  hall_r;
  logic [31:0] rounds_out_r;
  logic [45:0] total_r;
  logic [31:0] gyro_r;

  logic [15:0] angle;
  logic [15:0] old_angle;
  logic [15:0] old_offset;
  logic [31:0] old_rounds;
  logic [7:0]  old_fcount;
  logic        calib;
  logic [16:0] delta;
  logic [15:0] offset_nxt;
  logic [31:0] rounds_nxt;
  logic [7:0]  fcount_nxt;
  logic [45:0] total_nxt;
  logic        upd;

  assign item_pop  = item_valid && (!out_valid_r || out_ready);
  assign upd       = item_pop && !item.is_gyro;
  assign out_valid = out_valid_r;

  assign angle      = item.hi[31:16];
  assign old_angle  = angle_r[item.slot];
  assign old_offset = offset_r[item.slot];
  assign old_rounds = rounds_r[item.slot];
  assign old_fcount = fcount_r[item.slot];
  assign calib      = item.counted && (old_fcount < item.limit);
  assign delta      = {1'b0, angle} - {1'b0, old_angle};

  always_comb begin
    rounds_nxt = old_rounds;
    offset_nxt = old_offset;
    fcount_nxt = old_fcount;
    if (item.counted && old_fcount != 8'hFF) begin
      fcount_nxt = old_fcount + 8'd1;
    end
    if (calib) begin
      offset_nxt = angle;
    end else if ($signed(delta) > $signed(TURN_HALF)) begin
      if (old_rounds != 32'h8000_0000) begin
        rounds_nxt = old_rounds - 32'd1;
      end
    end else if ($signed(delta) < -$signed(TURN_HALF)) begin
      if (old_rounds != 32'h7FFF_FFFF) begin
        rounds_nxt = old_rounds + 32'd1;
      end
    end
    total_nxt = {rounds_nxt[31], rounds_nxt, 13'd0} + {30'd0, angle} - {30'd0, offset_nxt};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        angle_r[i]  <= '0;
        offset_r[i] <= '0;
        rounds_r[i] <= '0;
        fcount_r[i] <= '0;
      end
    end else if (upd) begin
      angle_r[item.slot]  <= angle;
      offset_r[item.slot] <= offset_nxt;
      rounds_r[item.slot] <= rounds_nxt;
      fcount_r[item.slot] <= fcount_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (item_pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_pop) begin
      source_r <= item.src;
      if (item.is_gyro) begin
        calib_r      <= 1'b0;
        raw_angle_r  <= '0;
        speed_r      <= '0;
        cur_r        <= '0;
        hall_r       <= '0;
        rounds_out_r <= '0;
        total_r      <= '0;
        gyro_r       <= item.hi;
      end else begin
        calib_r      <= calib;
        raw_angle_r  <= angle;
        speed_r      <= calib ? 16'd0 : item.hi[15:0];
        cur_r        <= calib ? 14'd0 : item.cur;
        hall_r       <= calib ? 8'd0 : item.hall;
        rounds_out_r <= rounds_nxt;
        total_r      <= total_nxt;
        gyro_r       <= '0;
      end
    end
  end

  assign source        = source_r;
  assign calibrating   = calib_r;
  assign raw_angle     = raw_angle_r;
  assign rotor_speed   = speed_r;
  assign drive_current = cur_r;
  assign hall_value    = hall_r;
  assign round_count   = rounds_out_r;
  assign accum_angle   = total_r;
  assign gyro_angle    = gyro_r;

endmodule

// File: src/motor_feedback_frame_decoder.sv
// ----------------------------------------------------------------------------
// motor_feedback_frame_decoder
// can feedback frame decoder with multi-turn motor angle tracking
// ----------------------------------------------------------------------------
// Takes one received frame per cycle while the queue has room. The front end
// matches the id against the configured ids and scales the current
// combinationally, then writes the item into a two-entry queue; frames with an
// unknown id are dropped there. The back end does the read-modify-write of
// the selected motor's angle, offset, round count and frame count and
// registers the result, so frames for the same motor may follow each other
// directly. Each frame passes a queue entry and then the output register, and
// the block sustains one frame per cycle while the result side keeps up.
// ----------------------------------------------------------------------------
module motor_feedback_frame_decoder import mffd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // frame_id[10:0], bytes_high[42:11], bytes_low[74:43]
  input  logic [79:0]           in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // raw_angle[15:0], rotor_speed[31:16], drive_current[45:32], hall_value[53:46],
  // round_count[85:54], accum_angle[131:86], gyro_angle[163:132]
  output logic [167:0]          out_tdata,
  // source[2:0], calibrating[3]
  output logic [7:0]            out_tuser,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  cfg_t        cfg;
  item_t       front_item;
  item_t       head;
  logic        match;
  logic        q_full;
  logic        q_not_empty;
  logic        q_pop;
  logic        push;

  logic [2:0]  source;
  logic        calibrating;
  logic [15:0] raw_angle;
  logic [15:0] rotor_speed;
  logic [13:0] drive_current;
  logic [7:0]  hall_value;
  logic [31:0] round_count;
  logic [45:0] accum_angle;
  logic [31:0] gyro_angle;

  mffd_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  mffd_front u_front (
    .cfg        (cfg),
    .frame_id   (in_tdata[10:0]),
    .bytes_high (in_tdata[42:11]),
    .bytes_low  (in_tdata[74:43]),
    .match      (match),
    .item       (front_item)
  );

  assign in_tready = !q_full;
  assign push      = in_tvalid && in_tready && match;

  mffd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (front_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (head)
  );

  mffd_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .item_valid    (q_not_empty),
    .item          (head),
    .item_pop      (q_pop),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .source        (source),
    .calibrating   (calibrating),
    .raw_angle     (raw_angle),
    .rotor_speed   (rotor_speed),
    .drive_current (drive_current),
    .hall_value    (hall_value),
    .round_count   (round_count),
    .accum_angle   (accum_angle),
    .gyro_angle    (gyro_angle)
  );

  assign out_tdata = {4'd0, gyro_angle, accum_angle, round_count, hall_value,
                      drive_current, rotor_speed, raw_angle};
  assign out_tuser = {4'd0, calibrating, source};

endmodule

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the motor feedback frame decoder
// ----------------------------------------------------------------------------
// Drives received frames into the input stream and checks every decoded item
// against the probe table or an in-bench predictor of the per-motor angle,
// offset, turn count and calibration state. A directed table covers the field
// extremes, both current rounding directions, the turn boundaries, calibration
// and unknown ids. Random traffic then runs under several id maps: calibration
// counts of zero and of the maximum, the id range at the top of the id space,
// and clashing ids. Both stream sides idle at random, with a calm stretch, a
// long result stall and a full drain in between.
// ----------------------------------------------------------------------------
module tb_top import mffd_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int HALF_TURN   = 4096;
  localparam int FULL_TURN   = 8192;
  localparam int ROUTE_NONE  = -1;
  localparam int ROUTE_GYRO  = -2;
  localparam int SETTLE      = 12;
  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 80;

  typedef struct packed {
    logic [2:0]         source;
    logic               calibrating;
    logic [15:0]        raw_angle;
    logic signed [15:0] rotor_speed;
    logic signed [13:0] drive_current;
    logic [7:0]         hall_value;
    logic signed [31:0] round_count;
    logic signed [45:0] accum_angle;
    logic signed [31:0] gyro_angle;
  } feedback_t;

  typedef struct packed {
    logic [10:0] id;
    logic [31:0] hi;
    logic [31:0] lo;
    bit          typed;
    bit          fires;
    feedback_t   want;
  } probe_t;

  // ids below assume the reset id map
  localparam int NPROBES = 20;
  localparam probe_t PROBES [NPROBES] = '{
    '{11'd1025, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 1'b1,
      '{source: SRC_GYRO, gyro_angle: 32'sh8000_0000, default: 0}},
    '{11'd1025, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1, 1'b1,
      '{source: SRC_GYRO, gyro_angle: 32'sh7FFF_FFFF, default: 0}},
    '{11'd1025, 32'h0000_0000, 32'h1234_5678, 1'b1, 1'b1,
      '{source: SRC_GYRO, default: 0}},
    '{11'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, '{default: 0}},
    '{11'd2047, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, '{default: 0}},
    '{11'd513, 32'hFFFF_1234, 32'h89AB_CDEF, 1'b1, 1'b1,
      '{source: 3'd0, calibrating: 1'b1, raw_angle: 16'hFFFF, default: 0}},
    '{11'd516, 32'h0000_8000, 32'h8000_FF00, 1'b1, 1'b1,
      '{source: 3'd3, calibrating: 1'b1, default: 0}},
    '{11'd519, 32'h1FFF_0000, 32'h0000_0000, 1'b1, 1'b1,
      '{source: SRC_POKE, calibrating: 1'b1, raw_angle: 16'h1FFF, default: 0}},
    '{11'd517, 32'h0000_8000, 32'h8000_FFFF, 1'b1, 1'b1,
      '{source: SRC_YAW, rotor_speed: 16'sh8000, drive_current: 14'sd6553,
        hall_value: 8'hFF, default: 0}},
    '{11'd517, 32'h1000_7FFF, 32'h7FFF_0000, 1'b1, 1'b1,
      '{source: SRC_YAW, raw_angle: 16'h1000, rotor_speed: 16'sh7FFF,
        drive_current: -14'sd6553, accum_angle: 46'sd4096, default: 0}},
    '{11'd517, 32'h2001_0001, 32'h0005_AB00, 1'b1, 1'b1,
      '{source: SRC_YAW, raw_angle: 16'h2001, rotor_speed: 16'sd1,
        drive_current: -14'sd1, hall_value: 8'hAB, round_count: -32'sd1,
        accum_angle: 46'sd1, default: 0}},
    '{11'd517, 32'h1001_FFFF, 32'hFFFB_0000, 1'b0, 1'b0, '{default: 0}},
    '{11'd517, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, '{default: 0}},
    '{11'd518, 32'hFFFF_0000, 32'h0004_0100, 1'b0, 1'b0, '{default: 0}},
    '{11'd518, 32'h0000_0000, 32'hFFFC_0000, 1'b0, 1'b0, '{default: 0}},
    '{11'd514, 32'h4000_5555, 32'hAAAA_AAAA, 1'b0, 1'b0, '{default: 0}},
    '{11'd515, 32'h8000_AAAA, 32'h5555_5555, 1'b0, 1'b0, '{default: 0}},
    '{11'd519, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, '{default: 0}},
    '{11'd1024, 32'h1234_5678, 32'h9ABC_DEF0, 1'b0, 1'b0, '{default: 0}},
    '{11'd520, 32'hFEDC_BA98, 32'h7654_3210, 1'b0, 1'b0, '{default: 0}}
  };

  logic                  clk;
  logic                  rst_n       = 1'b0;
  logic                  in_tvalid   = 1'b0;
  logic                  in_tready;
  logic [79:0]           in_tdata    = '0;
  logic                  out_tvalid;
  logic                  out_tready  = 1'b0;
  logic [167:0]          out_tdata;
  logic [7:0]            out_tuser;
  logic                  cfg_psel    = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr   = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata  = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  // predictor state
  cfg_t               ids;
  logic [15:0]        enc_angle  [SLOTS];
  logic [15:0]        enc_offset [SLOTS];
  logic signed [31:0] turns      [SLOTS];
  logic [7:0]         seen       [SLOTS];

  feedback_t pending [$];
  int        errors   = 0;
  int        quiet    = 0;
  bit        calm     = 1'b0;
  bit [3:0]  hold_tag = '0;
  bit [3:0]  hold_seen = '0;
  int        hold_left = 0;

  motor_feedback_frame_decoder dut (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int route_id(input logic [10:0] id);
    int off;
    off = int'(id) - int'(ids.chassis_base_id);
    if (off >= 0 && off < CHASSIS_MOTORS) return off;
    if (id == ids.yaw_id) return int'(SLOT_YAW);
    if (id == ids.pitch_id) return int'(SLOT_PITCH);
    if (id == ids.poke_id) return int'(SLOT_POKE);
    if (id == ids.gyro_id) return ROUTE_GYRO;
    return ROUTE_NONE;
  endfunction

  function automatic bit decode_feedback(input logic [10:0] id, input logic [31:0] hi,
                                         input logic [31:0] lo, output feedback_t r);
    int          slot;
    int          delta;
    int          cur;
    longint      tot;
    logic [15:0] ang;
    logic [7:0]  lim;
    bit          calib;
    slot  = route_id(id);
    r     = '0;
    calib = 1'b0;
    if (slot == ROUTE_NONE) return 1'b0;
    if (slot == ROUTE_GYRO) begin
      r.source     = SRC_GYRO;
      r.gyro_angle = hi;
      return 1'b1;
    end
    ang = hi[31:16];
    if (slot < CHASSIS_MOTORS) r.source = slot[2:0];
    else if (slot == int'(SLOT_YAW)) r.source = SRC_YAW;
    else if (slot == int'(SLOT_PITCH)) r.source = SRC_PITCH;
    else r.source = SRC_POKE;
    if (slot < CHASSIS_MOTORS || slot == int'(SLOT_POKE)) begin
      lim   = (slot == int'(SLOT_POKE)) ? ids.poke_calib_frames : ids.chassis_calib_frames;
      calib = seen[slot] < lim;
      if (seen[slot] != 8'hFF) seen[slot]++;
    end
    r.raw_angle = ang;
    if (calib) begin
      enc_angle[slot]  = ang;
      enc_offset[slot] = ang;
      r.calibrating    = 1'b1;
    end else begin
      delta = int'(ang) - int'(enc_angle[slot]);
      enc_angle[slot] = ang;
      if (delta > HALF_TURN) begin
        if (turns[slot] != 32'sh8000_0000) turns[slot]--;
      end else if (delta < -HALF_TURN) begin
        if (turns[slot] != 32'sh7FFF_FFFF) turns[slot]++;
      end
      cur = int'($signed(lo[31:16])) / -5;
      r.rotor_speed   = hi[15:0];
      r.drive_current = cur[13:0];
      r.hall_value    = lo[15:8];
    end
    tot = longint'(turns[slot]) * FULL_TURN + longint'(enc_angle[slot])
          - longint'(enc_offset[slot]);
    r.round_count = turns[slot];
    r.accum_angle = tot[45:0];
    return 1'b1;
  endfunction

  // offers one frame and records what it should produce once accepted
  task automatic send_frame(input logic [10:0] id, input logic [31:0] hi,
                            input logic [31:0] lo, input bit typed, input bit fires,
                            input feedback_t want, output bit hit);
    feedback_t r;
    while (!calm && $urandom_range(0, 99) < 15) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'b0, lo, hi, id};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    hit = decode_feedback(id, hi, lo, r);
    if (typed) begin
      hit = fires;
      r   = want;
    end
    if (hit) pending.push_back(r);
  endtask

  task automatic drain(input int extra);
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending.size() != 0);
    repeat (extra) @(posedge clk);
  endtask

  task automatic reg_write(input reg_idx_t idx, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_ADDR_W'(4 * int'(idx));
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_CHASSIS_BASE:  ids.chassis_base_id      = value[10:0];
      REG_YAW_ID:        ids.yaw_id               = value[10:0];
      REG_PITCH_ID:      ids.pitch_id             = value[10:0];
      REG_POKE_ID:       ids.poke_id              = value[10:0];
      REG_GYRO_ID:       ids.gyro_id              = value[10:0];
      REG_CHASSIS_CALIB: ids.chassis_calib_frames = value[7:0];
      REG_POKE_CALIB:    ids.poke_calib_frames    = value[7:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_ids(input logic [31:0] base, input logic [31:0] yaw,
                         input logic [31:0] pitch, input logic [31:0] poke,
                         input logic [31:0] gyro, input logic [31:0] chassis_cal,
                         input logic [31:0] poke_cal);
    reg_write(REG_CHASSIS_BASE, base);
    reg_write(REG_YAW_ID, yaw);
    reg_write(REG_PITCH_ID, pitch);
    reg_write(REG_POKE_ID, poke);
    reg_write(REG_GYRO_ID, gyro);
    reg_write(REG_CHASSIS_CALIB, chassis_cal);
    reg_write(REG_POKE_CALIB, poke_cal);
  endtask

  // mostly frames for known ids, some noise, with an optional favored id
  task automatic run_traffic(input int n_hits, input logic [10:0] focus,
                             input int focus_pct);
    int          hits;
    int          pick;
    int          slot;
    int          step;
    logic [10:0] id;
    logic [31:0] hi;
    logic [31:0] lo;
    logic [15:0] prev;
    bit          hit;
    hits = 0;
    while (hits < n_hits) begin
      pick = $urandom_range(0, 99);
      if (pick < focus_pct) id = focus;
      else if (pick < focus_pct + 8) id = 11'($urandom());
      else begin
        case ($urandom_range(0, 4))
          0:       id = ids.chassis_base_id + 11'($urandom_range(0, CHASSIS_MOTORS - 1));
          1:       id = ids.yaw_id;
          2:       id = ids.pitch_id;
          3:       id = ids.poke_id;
          default: id = ids.gyro_id;
        endcase
      end
      hi   = $urandom();
      lo   = $urandom();
      slot = route_id(id);
      prev = (slot >= 0) ? enc_angle[slot] : 16'h0;
      case ($urandom_range(0, 2))
        0: ;
        1: hi[31:16] = 16'($urandom_range(0, FULL_TURN - 1));
        default: begin
          step      = int'($urandom_range(0, 12000)) - 6000;
          hi[31:16] = 16'(int'(prev) + step);
        end
      endcase
      send_frame(id, hi, lo, 1'b0, 1'b0, '0, hit);
      if (hit) hits++;
    end
  endtask

  task automatic cmp(input string name, input longint want, input longint got);
    if (want != got) begin
      errors++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endtask

  // result side
  always @(posedge clk) begin
    if (hold_tag != hold_seen) begin
      hold_seen  <= hold_tag;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= calm || ($urandom_range(0, 99) >= 15);
    end
  end

  always @(posedge clk) begin
    feedback_t got;
    feedback_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.source        = out_tuser[2:0];
      got.calibrating   = out_tuser[3];
      got.raw_angle     = out_tdata[15:0];
      got.rotor_speed   = out_tdata[31:16];
      got.drive_current = out_tdata[45:32];
      got.hall_value    = out_tdata[53:46];
      got.round_count   = out_tdata[85:54];
      got.accum_angle   = out_tdata[131:86];
      got.gyro_angle    = out_tdata[163:132];
      if (pending.size() == 0) begin
        errors++;
        $error("item from source %0d with nothing pending", got.source);
      end else begin
        want = pending.pop_front();
        cmp("source", want.source, got.source);
        cmp("calibrating", want.calibrating, got.calibrating);
        cmp("raw_angle", want.raw_angle, got.raw_angle);
        cmp("rotor_speed", want.rotor_speed, got.rotor_speed);
        cmp("drive_current", want.drive_current, got.drive_current);
        cmp("hall_value", want.hall_value, got.hall_value);
        cmp("round_count", want.round_count, got.round_count);
        cmp("accum_angle", want.accum_angle, got.accum_angle);
        cmp("gyro_angle", want.gyro_angle, got.gyro_angle);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    bit hit;
    ids = '{chassis_base_id: 11'd513, yaw_id: 11'd517, pitch_id: 11'd518,
            poke_id: 11'd519, gyro_id: 11'd1025, chassis_calib_frames: 8'd51,
            poke_calib_frames: 8'd10};
    for (int s = 0; s < SLOTS; s++) begin
      enc_angle[s]  = '0;
      enc_offset[s] = '0;
      turns[s]      = '0;
      seen[s]       = '0;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (PROBES[i])
      send_frame(PROBES[i].id, PROBES[i].hi, PROBES[i].lo, PROBES[i].typed,
                 PROBES[i].fires, PROBES[i].want, hit);
    drain(SETTLE);

    // no chassis calibration, longest poke calibration
    set_ids(0, 2047, 4, 5, 6, 0, 255);
    calm <= 1'b1;
    run_traffic(150, 11'd0, 0);
    calm <= 1'b0;
    run_traffic(100, 11'd0, 0);
    drain(SETTLE);

    // chassis range at the top of the id space, frame count runs into saturation
    set_ids(2044, 100, 101, 102, 103, 255, 0);
    hold_tag <= hold_tag + 1'b1;
    run_traffic(400, 11'd2044, 70);
    drain(SETTLE);

    // clashing ids: chassis range over yaw, pitch over poke and gyro
    set_ids(300, 302, 800, 800, 800, 3, 5);
    run_traffic(150, 11'd302, 20);
    drain(0);
    run_traffic(150, 11'd800, 20);
    drain(SETTLE);

    // random map, upper write bits set at random
    set_ids($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
            $urandom_range(0, 7), $urandom_range(0, 7));
    run_traffic(150, 11'd0, 0);
    drain(SETTLE);

    if (errors == 0 && pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
